>>> src/pea_pkg.sv
package pea_pkg;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_NOMEM   = 3'd2;
   localparam logic [2:0] ST_BADF    = 3'd3;
   localparam logic [2:0] ST_NOSYS   = 3'd4;
   localparam logic [2:0] ST_EXIST   = 3'd5;
   localparam logic [2:0] ST_FULL    = 3'd6;

   localparam int FL_SHARED    = 0;
   localparam int FL_PRIVATE   = 1;
   localparam int FL_FIXED     = 4;
   localparam int FL_ANON      = 5;
   localparam int FL_NOREPLACE = 20;

   localparam logic OP_MAP   = 1'b0;
   localparam logic OP_UNMAP = 1'b1;

   // Request facts settled before the table is touched.
   typedef struct packed {
      logic       done;
      logic [2:0] status;
      logic       is_map;
      logic       fixed;
   } decode_type;

endpackage

>>> src/page_extent_allocator.sv
// Channel | Ports                                  | Direction
// req     | req_valid/req_ready + six fields       | in
// rsp     | rsp_valid/rsp_ready, status, address   | out
// csr     | csr_write_enable, csr_write_data       | in
// One request is worked at a time. A request that fails its checks, a fixed
// map or an unmap of address zero goes through idle, check and reply states. A
// table walk passes the read and evaluate states for each entry read (one memory
// read port), and a shift for insert or drop passes its read and write states
// for each entry moved; walk and shift together cover the table once.
// Reset clears the count, the bump mark, the base address and control; the table
// holds junk until written. A stalled response holds the block in its reply state.
module page_extent_allocator #(
   parameter int ARENA_PAGES = 16384,
   parameter int MAX_EXTENTS = 64,
   parameter int PAGE_BITS   = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [63:0] req_address,
   input  logic [63:0] req_length_bytes,
   input  logic [31:0] req_map_flags,
   input  logic signed [31:0] req_file_handle,
   input  logic signed [63:0] req_file_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_mapped_address,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);
   localparam int PW = $clog2(ARENA_PAGES + 1);
   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int EW = 2 * PW;
   localparam logic [63:0] PG_MASK = (64'd1 << PAGE_BITS) - 64'd1;
   localparam logic [63:0] ARENA_BYTES = 64'(ARENA_PAGES) << PAGE_BITS;
   localparam logic [63:0] ARENA_P = 64'(ARENA_PAGES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);

   localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_RD = 4'd2,
      S_EVAL = 4'd3, S_SHRD = 4'd4, S_SHWR = 4'd5, S_PREV = 4'd6,
      S_PEVAL = 4'd7, S_RESP = 4'd8, S_NXRD = 4'd9, S_NXEV = 4'd10;

   logic [EW-1:0] mem [MAX_EXTENTS];
   logic [EW-1:0] rdata_ff;
   logic [IW-1:0] raddr;
   logic          wen;
   logic [IW-1:0] waddr;
   logic [EW-1:0] wdata;

   logic [3:0]    state_ff, state_in;
   logic [63:0]   base_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] bump_ff, bump_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          op_ff;
   logic [63:0]   addr_ff, len_ff, off_ff;
   logic [31:0]   flags_ff;
   logic          fdneg_ff;
   logic [2:0]    st_ff, st_in;
   logic [63:0]   out_ff, out_in;
   logic [PW-1:0] s_ff, s_in, n_ff, n_in;
   logic          shup_ff, shup_in;   // 1 shift up for insert, 0 down for drop
   logic [CW-1:0] stop_ff, stop_in;
   logic [PW-1:0] plen_ff, plen_in;   // previous extent length kept for joins with it
   logic          jn_ff, jn_in;

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   pea_pkg::decode_type dec;
   logic [63:0] base_al, pages64, rel64;
   always_comb begin
      logic [63:0] kind;
      base_al = base_ff & ~PG_MASK;
      pages64 = (len_ff + PG_MASK) >> PAGE_BITS;
      dec = '0;
      dec.is_map = (op_ff == pea_pkg::OP_MAP);
      kind = {62'd0, flags_ff[pea_pkg::FL_PRIVATE], flags_ff[pea_pkg::FL_SHARED]};
      dec.fixed = flags_ff[pea_pkg::FL_FIXED] | flags_ff[pea_pkg::FL_NOREPLACE];
      rel64 = addr_ff - base_al;
      dec.status = pea_pkg::ST_OK;
      if (dec.is_map) begin
         dec.done = 1'b1;
         if (len_ff == 64'd0) dec.status = pea_pkg::ST_INVALID;
         else if (len_ff >= 64'h7FFF_FFFF_FFFF_FFFF) dec.status = pea_pkg::ST_NOMEM;
         else if (off_ff[63] || (off_ff & PG_MASK) != 64'd0)
            dec.status = pea_pkg::ST_INVALID;
         else if (kind != 64'd1 && kind != 64'd2) dec.status = pea_pkg::ST_INVALID;
         else if (!flags_ff[pea_pkg::FL_ANON])
            dec.status = fdneg_ff ? pea_pkg::ST_BADF : pea_pkg::ST_NOSYS;
         else if (pages64 > ARENA_P) dec.status = pea_pkg::ST_NOMEM;
         else if (dec.fixed) begin
            if ((addr_ff & PG_MASK) != 64'd0) dec.status = pea_pkg::ST_INVALID;
            else if (rel64 > ARENA_BYTES - (pages64 << PAGE_BITS))
               dec.status = pea_pkg::ST_NOMEM;
            else if (flags_ff[pea_pkg::FL_NOREPLACE] &&
                     (rel64 >> PAGE_BITS) < 64'(bump_ff))
               dec.status = pea_pkg::ST_EXIST;
         end else dec.done = 1'b0;
      end else begin
         dec.done = 1'b1;
         if (addr_ff == 64'd0) dec.status = pea_pkg::ST_OK;
         else if (len_ff == 64'd0 || len_ff > ~PG_MASK) dec.status = pea_pkg::ST_INVALID;
         else if (addr_ff < base_al) dec.status = pea_pkg::ST_INVALID;
         else if (rel64 > ARENA_BYTES) dec.status = pea_pkg::ST_INVALID;
         else if ((pages64 << PAGE_BITS) > ARENA_BYTES - rel64)
            dec.status = pea_pkg::ST_INVALID;
         else if ((addr_ff & PG_MASK) != 64'd0) dec.status = pea_pkg::ST_INVALID;
         else dec.done = 1'b0;
      end
   end

   logic [PW-1:0] e_s, e_n;
   assign e_s = rdata_ff[EW-1:PW];
   assign e_n = rdata_ff[PW-1:0];

   always_comb begin
      state_in = state_ff; count_in = count_ff; bump_in = bump_ff;
      idx_in = idx_ff; st_in = st_ff; out_in = out_ff; s_in = s_ff; n_in = n_ff;
      shup_in = shup_ff; stop_in = stop_ff; plen_in = plen_ff; jn_in = jn_ff;
      raddr = idx_ff[IW-1:0]; wen = 1'b0; waddr = idx_ff[IW-1:0]; wdata = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            s_in = PW'(rel64 >> PAGE_BITS);
            n_in = PW'(pages64);
            idx_in = '0; out_in = 64'd0;
            if (dec.done) begin
               st_in = dec.status;
               if (dec.is_map && dec.fixed && dec.status == pea_pkg::ST_OK) begin
                  out_in = addr_ff;
                  if ((64'(PW'(rel64 >> PAGE_BITS)) + pages64) > 64'(bump_ff))
                     bump_in = PW'(64'(PW'(rel64 >> PAGE_BITS)) + pages64);
               end
               state_in = S_RESP;
            end else begin
               st_in = pea_pkg::ST_OK;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               if (op_ff == pea_pkg::OP_MAP) begin
                  if (64'(bump_ff) > ARENA_P - 64'(n_ff)) st_in = pea_pkg::ST_NOMEM;
                  else begin
                     out_in = base_al + (64'(bump_ff) << PAGE_BITS);
                     bump_in = bump_ff + n_ff;
                  end
                  state_in = S_RESP;
               end else state_in = S_PREV;
            end else state_in = S_EVAL;
         end
         S_EVAL: begin
            if (op_ff == pea_pkg::OP_MAP) begin
               if (e_n >= n_ff) begin
                  out_in = base_al + (64'(e_s) << PAGE_BITS);
                  if (e_n > n_ff) begin
                     wen = 1'b1; wdata = {e_s + n_ff, e_n - n_ff};
                     state_in = S_RESP;
                  end else begin
                     shup_in = 1'b0; stop_in = count_ff - CW'(1);
                     count_in = count_ff - CW'(1);
                     state_in = S_SHRD;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end
            end else begin
               if (e_s < s_ff) begin
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end else state_in = S_PREV;
            end
         end
         S_PREV: begin
            jn_in = 1'b0;
            if (idx_ff != '0) begin
               raddr = IW'(idx_ff - CW'(1)); state_in = S_PEVAL;
            end else state_in = S_NXRD;
         end
         S_PEVAL: begin
            jn_in = (e_s + e_n == s_ff);
            plen_in = e_n;
            state_in = S_NXRD;
         end
         S_NXRD: state_in = S_NXEV;
         S_NXEV: begin
            if (idx_ff < count_ff && s_ff + n_ff == e_s) begin
               if (jn_ff) begin
                  wen = 1'b1; waddr = IW'(idx_ff - CW'(1));
                  wdata = {s_ff - plen_ff, plen_ff + n_ff + e_n};
                  shup_in = 1'b0; stop_in = count_ff - CW'(1);
                  count_in = count_ff - CW'(1);
                  state_in = S_SHRD;
               end else begin
                  wen = 1'b1; wdata = {s_ff, e_n + n_ff}; state_in = S_RESP;
               end
            end else if (jn_ff) begin
               wen = 1'b1; waddr = IW'(idx_ff - CW'(1));
               wdata = {s_ff - plen_ff, plen_ff + n_ff}; state_in = S_RESP;
            end else if (count_ff >= MAXC) begin
               st_in = pea_pkg::ST_FULL; state_in = S_RESP;
            end else begin
               shup_in = 1'b1; stop_in = idx_ff; idx_in = count_ff;
               count_in = count_ff + CW'(1);
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            if (shup_ff) begin
               if (idx_ff == stop_ff) begin
                  wen = 1'b1; wdata = {s_ff, n_ff}; state_in = S_RESP;
               end else begin
                  raddr = IW'(idx_ff - CW'(1)); state_in = S_SHWR;
               end
            end else begin
               if (idx_ff >= stop_ff) state_in = S_RESP;
               else begin
                  raddr = IW'(idx_ff + CW'(1)); state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            wen = 1'b1; wdata = rdata_ff;
            idx_in = shup_ff ? idx_ff - CW'(1) : idx_ff + CW'(1);
            state_in = S_SHRD;
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; bump_ff <= '0; base_ff <= 64'd0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; bump_ff <= bump_in;
         if (csr_write_enable) base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; st_ff <= st_in; out_ff <= out_in; s_ff <= s_in;
      n_ff <= n_in; shup_ff <= shup_in; stop_ff <= stop_in; plen_ff <= plen_in;
      jn_ff <= jn_in;
      if (req_valid && req_ready) begin
         op_ff <= req_operation; addr_ff <= req_address; len_ff <= req_length_bytes;
         flags_ff <= req_map_flags; fdneg_ff <= req_file_handle[31];
         off_ff <= req_file_offset;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = st_ff;
   assign rsp_mapped_address = (st_ff == pea_pkg::ST_OK) ? out_ff : 64'd0;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAXC) else $error("extent count past table size");
   a_bump: assert property (@(posedge clock) disable iff (reset)
      64'(bump_ff) <= ARENA_P) else $error("bump mark past arena");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
`endif
endmodule
